// File: hw/rtl/hcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared constants, state and command types of the huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int MAX_SYMBOLS_DEF = 64;
  localparam int MAX_CODE_LEN    = 24;
  localparam int FREQ_BITS       = 16;
  localparam int WGT_BITS        = FREQ_BITS + 1;
  localparam int SYM_BITS        = 8;
  localparam int CODE_BITS       = 23;
  localparam int DEPTH_BITS      = 5;
  localparam int MAX_LEN         = (MAX_CODE_LEN - 1 < CODE_BITS) ? MAX_CODE_LEN - 1 : CODE_BITS;
  localparam int STACK_DEPTH     = MAX_LEN + 2;
  localparam int STK_IW          = $clog2(STACK_DEPTH);
  localparam int SP_BITS         = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_LOAD, ST_CHK, ST_HINIT, ST_HREAD, ST_HCAP, ST_HNXT,
    ST_SD0, ST_SD1, ST_SD2, ST_SDF,
    ST_MCHK, ST_TM0, ST_TM1, ST_TM2, ST_MRG, ST_PU0, ST_PU1,
    ST_RINIT, ST_TD0, ST_TD1, ST_TD2,
    ST_WINIT, ST_WPOP, ST_WDEC, ST_ERR
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_HINIT, OP_HREAD, OP_HCAP, OP_HDEC,
    OP_SD0, OP_SD1, OP_SD2, OP_SDF,
    OP_TMRD, OP_TMTOPA, OP_TMTOPB, OP_TMLAST, OP_MERGE, OP_PU0, OP_PU1,
    OP_RINIT, OP_TDRD, OP_TDWL, OP_TDWR,
    OP_WINIT, OP_WPOP, OP_WEMIT, OP_WPUSH, OP_ERR
  } op_t;

  typedef struct packed {
    logic ovf;
    logic l_in;
    logic r_in;
    logic sd_stop;
    logic i_zero;
    logic hcnt_gt1;
    logic pi_zero;
    logic pu_lt;
    logic td_done;
    logic too_long;
    logic leaf;
    logic last_leaf;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// File: hw/rtl/hcb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer: load, heapify, merge loop, code assignment, tree walk.
// ----------------------------------------------------------------------------
module hcb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_last,
  input  wire hcb_pkg::status_t st,
  output hcb_pkg::op_t          op,
  output logic                  in_stall
);
  import hcb_pkg::*;

  state_t state_r, state_nxt;
  logic   in_heap_r, in_heap_nxt;
  logic   second_r, second_nxt;
  state_t ret_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      in_heap_r <= 1'b0;
      second_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_heap_r <= in_heap_nxt;
      second_r  <= second_nxt;
    end
  end

  // where a finished sift-down returns to
  always_comb begin
    if (in_heap_r) begin
      ret_state = ST_HNXT;
    end else if (!second_r) begin
      ret_state = ST_TM0;
    end else begin
      ret_state = ST_MRG;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_heap_nxt = in_heap_r;
    second_nxt  = second_r;
    op          = OP_NONE;
    in_stall    = 1'b1;
    case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op = OP_LOAD;
          if (in_last) state_nxt = ST_CHK;
        end
      end
      ST_CHK: state_nxt = st.ovf ? ST_ERR : ST_HINIT;
      ST_HINIT: begin
        op          = OP_HINIT;
        in_heap_nxt = 1'b1;
        second_nxt  = 1'b0;
        state_nxt   = ST_HREAD;
      end
      ST_HREAD: begin
        op        = OP_HREAD;
        state_nxt = ST_HCAP;
      end
      ST_HCAP: begin
        op        = OP_HCAP;
        state_nxt = ST_SD0;
      end
      ST_HNXT: begin
        if (st.i_zero) begin
          in_heap_nxt = 1'b0;
          state_nxt   = ST_MCHK;
        end else begin
          op        = OP_HDEC;
          state_nxt = ST_HREAD;
        end
      end
      ST_SD0, ST_SDF: begin
        op = (state_r == ST_SD0) ? OP_SD0 : OP_SDF;
        if ((state_r == ST_SD0) ? st.l_in : !st.sd_stop) begin
          state_nxt = (state_r == ST_SD0) ? ST_SD1 : ST_SD0;
        end else begin
          state_nxt = ret_state;
          if (!in_heap_r) second_nxt = !second_r;
        end
      end
      ST_SD1: begin
        op        = OP_SD1;
        state_nxt = st.r_in ? ST_SD2 : ST_SDF;
      end
      ST_SD2: begin
        op        = OP_SD2;
        state_nxt = ST_SDF;
      end
      ST_MCHK: state_nxt = st.hcnt_gt1 ? ST_TM0 : ST_RINIT;
      ST_TM0: begin
        op        = OP_TMRD;
        state_nxt = ST_TM1;
      end
      ST_TM1: begin
        op        = second_r ? OP_TMTOPB : OP_TMTOPA;
        state_nxt = ST_TM2;
      end
      ST_TM2: begin
        op        = OP_TMLAST;
        state_nxt = ST_SD0;
      end
      ST_MRG: begin
        op        = OP_MERGE;
        state_nxt = ST_PU0;
      end
      ST_PU0: begin
        op        = OP_PU0;
        state_nxt = st.pi_zero ? ST_MCHK : ST_PU1;
      end
      ST_PU1: begin
        op        = OP_PU1;
        state_nxt = st.pu_lt ? ST_PU0 : ST_MCHK;
      end
      ST_RINIT: begin
        op        = OP_RINIT;
        state_nxt = ST_TD0;
      end
      ST_TD0: begin
        if (st.td_done) begin
          state_nxt = st.too_long ? ST_ERR : ST_WINIT;
        end else begin
          op        = OP_TDRD;
          state_nxt = ST_TD1;
        end
      end
      ST_TD1: begin
        op        = OP_TDWL;
        state_nxt = ST_TD2;
      end
      ST_TD2: begin
        op        = OP_TDWR;
        state_nxt = ST_TD0;
      end
      ST_WINIT: begin
        op        = OP_WINIT;
        state_nxt = ST_WPOP;
      end
      ST_WPOP: begin
        op        = OP_WPOP;
        state_nxt = ST_WDEC;
      end
      ST_WDEC: begin
        if (st.leaf) begin
          if (st.out_free) begin
            op        = OP_WEMIT;
            state_nxt = st.last_leaf ? ST_LOAD : ST_WPOP;
          end
        end else begin
          op        = OP_WPUSH;
          state_nxt = ST_WPOP;
        end
      end
      ST_ERR: begin
        if (st.out_free) begin
          op        = OP_ERR;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/hcb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_dp
// Datapath: symbol and heap memories, tree memories, walk stack, output reg.
// ----------------------------------------------------------------------------
module hcb_dp #(
  parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire hcb_pkg::op_t                   op,
  output hcb_pkg::status_t                    st,
  input  wire logic [hcb_pkg::SYM_BITS-1:0]   in_symbol,
  input  wire logic [hcb_pkg::FREQ_BITS-1:0]  in_frequency,
  input  wire logic                           out_stall,
  output logic                                out_valid,
  output logic [hcb_pkg::SYM_BITS-1:0]        out_symbol,
  output logic [hcb_pkg::DEPTH_BITS-1:0]      out_code_length,
  output logic [hcb_pkg::CODE_BITS-1:0]       out_code_bits,
  output logic                                out_final_res,
  output logic                                out_error
);
  import hcb_pkg::*;

  localparam int NODE_MAX = 2 * MAX_SYMBOLS;
  localparam int IW       = $clog2(NODE_MAX);
  localparam int HW       = $clog2(MAX_SYMBOLS);
  localparam int CW       = $clog2(MAX_SYMBOLS + 1);
  localparam int LW       = HW + 2;

  typedef struct packed {
    logic [WGT_BITS-1:0] w;
    logic [IW-1:0]       node;
  } hent_t;

  // memories
  hent_t                 hmem   [MAX_SYMBOLS];
  logic [SYM_BITS-1:0]   symmem [MAX_SYMBOLS];
  logic [IW-1:0]         lmem   [NODE_MAX];
  logic [IW-1:0]         rmem   [NODE_MAX];
  logic [DEPTH_BITS-1:0] dmem   [NODE_MAX];
  logic [CODE_BITS-1:0]  cmem   [NODE_MAX];
  logic [IW-1:0]         stk_r  [STACK_DEPTH];

  hent_t                 hrd_r;
  logic [SYM_BITS-1:0]   symrd_r;
  logic [IW-1:0]         lrd_r, rrd_r;
  logic [DEPTH_BITS-1:0] drd_r;
  logic [CODE_BITS-1:0]  crd_r;

  // control and work registers
  logic [CW-1:0]       sym_cnt_r, hcnt_r, lcnt_r;
  logic                ovf_r, tl_r;
  logic [WGT_BITS-1:0] wtot_r;
  logic [HW-1:0]       hi_r, at_r, sel_r, pi_r;
  logic [IW-1:0]       next_r, ti_r, nd_r;
  hent_t               cur_r, best_r, a_r, b_r;
  logic [SP_BITS-1:0]  sp_r;
  logic                out_valid_r;

  // derived values
  logic                  room;
  logic [WGT_BITS-1:0]   wsum;
  logic [LW-1:0]         l_pos, r_pos, hcnt_x;
  logic [HW-1:0]         parent;
  logic [IW-1:0]         root;
  logic [DEPTH_BITS:0]   depth_inc;
  logic [SP_BITS-1:0]    sp_m1, sp_p1;
  logic                  sd1_lt, sd2_lt;
  logic                  clear_load;

  // heap memory port
  logic          h_we, h_re;
  logic [HW-1:0] h_wa, h_ra;
  hent_t         h_wd;

  // tree memory port
  logic                  t_we, t_re;
  logic [IW-1:0]         t_wa, t_ra;
  logic [DEPTH_BITS-1:0] t_wd_d;
  logic [CODE_BITS-1:0]  t_wd_c;

  assign room      = sym_cnt_r < CW'(MAX_SYMBOLS);
  assign wsum      = wtot_r + WGT_BITS'(in_frequency);
  assign l_pos     = {1'b0, at_r, 1'b1};
  assign r_pos     = l_pos + LW'(1);
  assign hcnt_x    = LW'(hcnt_r);
  assign parent    = (pi_r - HW'(1)) >> 1;
  assign root      = next_r - IW'(1);
  assign depth_inc = {1'b0, drd_r} + (DEPTH_BITS+1)'(1);
  assign sp_m1     = sp_r - SP_BITS'(1);
  assign sp_p1     = sp_r + SP_BITS'(1);
  assign sd1_lt    = hrd_r.w < cur_r.w;
  assign sd2_lt    = hrd_r.w < best_r.w;

  always_comb begin
    st.ovf       = ovf_r;
    st.l_in      = l_pos < hcnt_x;
    st.r_in      = r_pos < hcnt_x;
    st.sd_stop   = sel_r == at_r;
    st.i_zero    = hi_r == '0;
    st.hcnt_gt1  = hcnt_r > CW'(1);
    st.pi_zero   = pi_r == '0;
    st.pu_lt     = cur_r.w < hrd_r.w;
    st.td_done   = ti_r < IW'(sym_cnt_r);
    st.too_long  = tl_r;
    st.leaf      = nd_r < IW'(sym_cnt_r);
    st.last_leaf = lcnt_r == (sym_cnt_r - CW'(1));
    st.out_free  = !out_valid_r || !out_stall;
  end

  // heap memory port select
  always_comb begin
    h_we = 1'b0;
    h_wa = at_r;
    h_wd = cur_r;
    h_re = 1'b0;
    h_ra = '0;
    case (op)
      OP_LOAD: begin
        h_we      = room;
        h_wa      = sym_cnt_r[HW-1:0];
        h_wd.w    = WGT_BITS'(in_frequency);
        h_wd.node = IW'(sym_cnt_r);
      end
      OP_HREAD: begin
        h_re = 1'b1;
        h_ra = hi_r;
      end
      OP_SD0: begin
        if (l_pos < hcnt_x) begin
          h_re = 1'b1;
          h_ra = l_pos[HW-1:0];
        end else begin
          h_we = 1'b1;
        end
      end
      OP_SD1: begin
        h_re = r_pos < hcnt_x;
        h_ra = r_pos[HW-1:0];
      end
      OP_SDF: begin
        h_we = 1'b1;
        h_wd = (sel_r == at_r) ? cur_r : best_r;
      end
      OP_TMRD: h_re = 1'b1;
      OP_TMTOPA, OP_TMTOPB: begin
        h_re = 1'b1;
        h_ra = HW'(hcnt_r - CW'(1));
      end
      OP_PU0: begin
        if (pi_r == '0) begin
          h_we = 1'b1;
          h_wa = '0;
        end else begin
          h_re = 1'b1;
          h_ra = parent;
        end
      end
      OP_PU1: begin
        h_we = 1'b1;
        h_wa = pi_r;
        h_wd = (cur_r.w < hrd_r.w) ? hrd_r : cur_r;
      end
      default: h_we = 1'b0;
    endcase
  end

  // depth and code memory port select
  always_comb begin
    t_we   = 1'b0;
    t_wa   = root;
    t_wd_d = '0;
    t_wd_c = '0;
    t_re   = 1'b0;
    t_ra   = ti_r;
    case (op)
      OP_RINIT: t_we = 1'b1;
      OP_TDRD:  t_re = 1'b1;
      OP_TDWL: begin
        t_we   = 1'b1;
        t_wa   = lrd_r;
        t_wd_d = depth_inc[DEPTH_BITS-1:0];
        t_wd_c = {crd_r[CODE_BITS-2:0], 1'b0};
      end
      OP_TDWR: begin
        t_we   = 1'b1;
        t_wa   = rrd_r;
        t_wd_d = depth_inc[DEPTH_BITS-1:0];
        t_wd_c = {crd_r[CODE_BITS-2:0], 1'b1};
      end
      OP_WPOP: begin
        t_re = 1'b1;
        t_ra = stk_r[sp_m1[STK_IW-1:0]];
      end
      default: t_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) hmem[h_wa] <= h_wd;
    if (h_re) hrd_r <= hmem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD && room) symmem[sym_cnt_r[HW-1:0]] <= in_symbol;
    if (op == OP_WPOP) symrd_r <= symmem[t_ra[HW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (op == OP_MERGE) begin
      lmem[next_r] <= a_r.node;
      rmem[next_r] <= b_r.node;
    end
    if (t_re) begin
      lrd_r <= lmem[t_ra];
      rrd_r <= rmem[t_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      dmem[t_wa] <= t_wd_d;
      cmem[t_wa] <= t_wd_c;
    end
    if (t_re) begin
      drd_r <= dmem[t_ra];
      crd_r <= cmem[t_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_WINIT) stk_r[0] <= root;
    if (op == OP_WPUSH) begin
      stk_r[sp_r[STK_IW-1:0]]  <= rrd_r;
      stk_r[sp_p1[STK_IW-1:0]] <= lrd_r;
    end
  end

  assign clear_load = (op == OP_ERR) || (op == OP_WEMIT && st.last_leaf);

  // load state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      wtot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clear_load) begin
        sym_cnt_r <= '0;
        ovf_r     <= 1'b0;
        wtot_r    <= '0;
      end else if (op == OP_LOAD) begin
        if (room) begin
          sym_cnt_r <= sym_cnt_r + CW'(1);
        end
        // dropped symbol or saturated total
        ovf_r <= ovf_r | !room | wsum[FREQ_BITS];
        if (wsum[FREQ_BITS]) begin
          wtot_r <= WGT_BITS'(1) << FREQ_BITS;
        end else begin
          wtot_r <= wsum;
        end
      end
      if (op == OP_WEMIT || op == OP_ERR) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= '0;
      sp_r   <= '0;
      tl_r   <= 1'b0;
    end else begin
      case (op)
        OP_HINIT: begin
          hcnt_r <= sym_cnt_r;
          hi_r   <= HW'(sym_cnt_r >> 1);
          next_r <= IW'(sym_cnt_r);
        end
        OP_HREAD: at_r <= hi_r;
        OP_HCAP:  cur_r <= hrd_r;
        OP_HDEC:  hi_r <= hi_r - HW'(1);
        OP_SD1: begin
          best_r <= sd1_lt ? hrd_r : cur_r;
          sel_r  <= sd1_lt ? l_pos[HW-1:0] : at_r;
        end
        OP_SD2: begin
          if (sd2_lt) begin
            best_r <= hrd_r;
            sel_r  <= r_pos[HW-1:0];
          end
        end
        OP_SDF:    at_r <= sel_r;
        OP_TMTOPA: a_r <= hrd_r;
        OP_TMTOPB: b_r <= hrd_r;
        OP_TMLAST: begin
          cur_r  <= hrd_r;
          hcnt_r <= hcnt_r - CW'(1);
          at_r   <= '0;
        end
        OP_MERGE: begin
          cur_r.w    <= a_r.w + b_r.w;
          cur_r.node <= next_r;
          pi_r       <= hcnt_r[HW-1:0];
          hcnt_r     <= hcnt_r + CW'(1);
          next_r     <= next_r + IW'(1);
        end
        OP_PU1: begin
          if (cur_r.w < hrd_r.w) pi_r <= parent;
        end
        OP_RINIT: begin
          ti_r <= root;
          tl_r <= 1'b0;
        end
        OP_TDWL: begin
          if (depth_inc > (DEPTH_BITS+1)'(MAX_LEN)) tl_r <= 1'b1;
        end
        OP_TDWR: ti_r <= ti_r - IW'(1);
        OP_WINIT: begin
          sp_r   <= SP_BITS'(1);
          lcnt_r <= '0;
        end
        OP_WPOP: begin
          nd_r <= t_ra;
          sp_r <= sp_m1;
        end
        OP_WPUSH: sp_r <= sp_r + SP_BITS'(2);
        OP_WEMIT: lcnt_r <= lcnt_r + CW'(1);
        default: tl_r <= tl_r;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (op == OP_WEMIT) begin
      out_symbol      <= symrd_r;
      out_code_length <= drd_r;
      out_code_bits   <= crd_r;
      out_final_res   <= st.last_leaf;
      out_error       <= 1'b0;
    end else if (op == OP_ERR) begin
      out_symbol      <= '0;
      out_code_length <= '0;
      out_code_bits   <= '0;
      out_final_res   <= 1'b1;
      out_error       <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: hw/rtl/huffman_code_builder_top.sv
`default_nettype none
// sequence: symbols are taken while in_stall is low; after the last one the heap is built by
//   sift-downs that step one heap level at a time, 2 extractions plus one insert per merge,
//   code assignment per internal node, then a walk that pops each tree node
// throughput: one set at a time, bounded by the single-port heap memory
// reset: synchronous active-low rst_n clears counters and control; memories need no clear
// ----------------------------------------------------------------------------
// huffman_code_builder_top
// Huffman code construction with a binary min-heap and a tree walk.
// ----------------------------------------------------------------------------
module huffman_code_builder_top #(
  parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input transaction: one symbol/frequency pair
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [hcb_pkg::SYM_BITS-1:0]   in_symbol,
  input  wire logic [hcb_pkg::FREQ_BITS-1:0]  in_frequency,
  input  wire logic                           in_last,
  // result transaction: one code per leaf, or one error
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [hcb_pkg::SYM_BITS-1:0]        out_symbol,
  output logic [hcb_pkg::DEPTH_BITS-1:0]      out_code_length,
  output logic [hcb_pkg::CODE_BITS-1:0]       out_code_bits,
  output logic                                out_final_res,
  output logic                                out_error
);
  import hcb_pkg::*;

  // command from sequencer, status back from datapath
  op_t     op;
  status_t st;

  // controller walks the phases: load, heapify, merge, assign codes, emit
  hcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .st       (st),
    .op       (op),
    .in_stall (in_stall)
  );

  // datapath holds all storage and the output register
  hcb_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .st              (st),
    .in_symbol       (in_symbol),
    .in_frequency    (in_frequency),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_symbol      (out_symbol),
    .out_code_length (out_code_length),
    .out_code_bits   (out_code_bits),
    .out_final_res   (out_final_res),
    .out_error       (out_error)
  );

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the huffman code builder: symbol sets are streamed in, a local
// heap-based code builder predicts every code result, and a monitor checks
// each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import hcb_pkg::*;

  localparam int NSYM       = 64;
  localparam int LIMIT_CYC  = 900000;
  localparam int DRAIN_CYC  = 3000;
  localparam int QUIET_LO   = 1500;    // window with no idling on either side
  localparam int QUIET_HI   = 4500;
  localparam int HOLD_START = 6000;    // long receiver hold-off
  localparam int HOLD_LEN   = 600;

  typedef struct packed {
    logic [SYM_BITS-1:0]  sym;
    logic [FREQ_BITS-1:0] freq;
    logic                 last;
  } pair_t;

  typedef struct packed {
    logic [SYM_BITS-1:0]   sym;
    logic [DEPTH_BITS-1:0] len;
    logic [CODE_BITS-1:0]  code;
    logic                  fin;
    logic                  err;
  } code_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SYM_BITS-1:0] in_symbol = '0;
  logic [FREQ_BITS-1:0] in_frequency = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SYM_BITS-1:0] out_symbol;
  logic [DEPTH_BITS-1:0] out_code_length;
  logic [CODE_BITS-1:0] out_code_bits;
  logic out_final_res;
  logic out_error;

  huffman_code_builder_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_symbol(in_symbol),
    .in_frequency(in_frequency), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_symbol(out_symbol),
    .out_code_length(out_code_length), .out_code_bits(out_code_bits),
    .out_final_res(out_final_res), .out_error(out_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pair_t pair_q[$];      // pairs waiting to be offered
  code_t code_q[$];      // predicted code results, oldest first
  bit    fill_done = 0;
  int    cycle = 0;
  int    mismatches = 0;

  // ---------------------------------------------------------------------------
  // code builder model: load state, node memories and the min-heap
  // ---------------------------------------------------------------------------
  logic [16:0] wt [2*NSYM];
  logic [7:0]  leaf_sym [NSYM];
  int          lchild [2*NSYM];
  int          rchild [2*NSYM];
  int          depth [2*NSYM];
  logic [63:0] path [2*NSYM];
  int          heap [NSYM];
  int          heap_n;
  int          loaded;
  bit          overflowed;
  logic [16:0] total;

  function automatic void clear_set();
    heap_n = 0;
    loaded = 0;
    overflowed = 0;
    total = '0;
  endfunction

  function automatic void push_error();
    code_t c;
    c = '{sym: '0, len: '0, code: '0, fin: 1'b1, err: 1'b1};
    code_q.push_back(c);
    clear_set();
  endfunction

  // strict less-than keeps the tie order of the block
  function automatic void sift_down(int at);
    int best, l, r, t;
    while (1) begin
      best = at;
      l = 2*at + 1;
      r = 2*at + 2;
      if (l < heap_n && wt[heap[l]] < wt[heap[best]]) best = l;
      if (r < heap_n && wt[heap[r]] < wt[heap[best]]) best = r;
      if (best == at) break;
      t = heap[best];
      heap[best] = heap[at];
      heap[at] = t;
      at = best;
    end
  endfunction

  function automatic int pop_min();
    int top;
    top = heap[0];
    heap[0] = heap[heap_n-1];
    heap_n--;
    sift_down(0);
    return top;
  endfunction

  function automatic void push_node(int nd);
    int i;
    i = heap_n;
    heap_n++;
    while (i != 0 && wt[nd] < wt[heap[(i-1)/2]]) begin
      heap[i] = heap[(i-1)/2];
      i = (i-1)/2;
    end
    heap[i] = nd;
  endfunction

  function automatic void build_codes();
    int n, nxt, root, a, b, sp, nd, cnt, l, r;
    bit too_long;
    int stk [2*NSYM];
    code_t c;
    n = loaded;
    for (int i = 0; i < n; i++) heap[i] = i;
    heap_n = n;
    for (int i = n/2; i >= 0; i--) sift_down(i);
    nxt = n;
    while (heap_n > 1) begin
      a = pop_min();
      b = pop_min();
      wt[nxt] = wt[a] + wt[b];
      lchild[nxt] = a;
      rchild[nxt] = b;
      push_node(nxt);
      nxt++;
    end
    root = nxt - 1;
    // parents come after their children, so walk node indexes downward
    depth[root] = 0;
    path[root] = '0;
    too_long = 0;
    for (int i = root; i >= n; i--) begin
      l = lchild[i];
      r = rchild[i];
      depth[l] = depth[i] + 1;
      depth[r] = depth[i] + 1;
      path[l] = path[i] << 1;
      path[r] = (path[i] << 1) | 64'd1;
      if (depth[i] + 1 > MAX_LEN) too_long = 1;
    end
    if (too_long) begin
      push_error();
      return;
    end
    cnt = 0;
    stk[0] = root;
    sp = 1;
    while (sp > 0) begin
      sp--;
      nd = stk[sp];
      if (nd < n) begin
        c.sym = leaf_sym[nd];
        c.len = depth[nd][DEPTH_BITS-1:0];
        c.code = path[nd][CODE_BITS-1:0];
        c.fin = 1'b0;
        c.err = 1'b0;
        code_q.push_back(c);
        cnt++;
      end else begin
        stk[sp] = rchild[nd];
        stk[sp+1] = lchild[nd];
        sp = sp + 2;
      end
    end
    if (cnt > 0) code_q[code_q.size()-1].fin = 1'b1;
    clear_set();
  endfunction

  function automatic void load_pair(pair_t p);
    if (loaded < NSYM) begin
      leaf_sym[loaded] = p.sym;
      wt[loaded] = {1'b0, p.freq};
      loaded++;
    end else begin
      overflowed = 1;
    end
    total = total + p.freq;
    if (total >= 17'h10000) begin
      total = 17'h10000;
      overflowed = 1;
    end
    if (p.last) begin
      if (overflowed) push_error();
      else build_codes();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic void add_pair(int s, int f, bit l);
    pair_t p;
    p.sym = s[7:0];
    p.freq = f[15:0];
    p.last = l;
    pair_q.push_back(p);
  endfunction

  function automatic void add_set(int n, int cap, int zero_pct);
    int f;
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(99) < zero_pct) ? 0 : $urandom_range(cap, 1);
      add_pair($urandom_range(255), f, i == n-1);
    end
  endfunction

  initial begin
    int kind, n, fa, fb;
    // lone symbol at both extremes of symbol and frequency
    add_pair(255, 65535, 1);
    add_pair(0, 0, 1);
    // two symbols, total exactly at the largest legal value
    add_pair(0, 32768, 0);
    add_pair(255, 32767, 1);
    // total one past the limit gives an error
    add_pair(85, 65535, 0);
    add_pair(170, 1, 1);
    // ties everywhere
    for (int i = 0; i < 5; i++) add_pair(i + 10, 7, i == 4);
    // zero weights in a set
    add_pair(1, 0, 0);
    add_pair(2, 0, 0);
    add_pair(3, 5, 0);
    add_pair(4, 0, 1);
    // fibonacci-like weights behind a run of zeros build a deep chain
    fa = 1;
    fb = 1;
    for (int i = 0; i < 4; i++) add_pair(100 + i, 0, 0);
    for (int i = 0; i < 20; i++) begin
      add_pair(i, fa, i == 19);
      n = fa + fb;
      fa = fb;
      fb = n;
    end
    // random sets until about 480 pairs are queued
    while (pair_q.size() < 480) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        add_pair($urandom_range(255), $urandom_range(65535), 1);
      end else if (kind < 16) begin
        n = $urandom_range(6, 2);
        add_set(n, 65535, 0);
      end else if (kind < 19) begin
        add_set($urandom_range(70, NSYM + 1), 100, 5);
      end else if (kind < 24) begin
        add_set($urandom_range(40, 24), 0, 100);   // all zero weights
      end else begin
        n = ($urandom_range(9) == 0) ? $urandom_range(NSYM, 17) : $urandom_range(16, 2);
        add_set(n, 65535 / n, 5);
      end
    end
    fill_done = 1;
  end

  // ---------------------------------------------------------------------------
  // driver: prediction happens at the edge the pair is taken
  // ---------------------------------------------------------------------------
  wire quiet = (cycle >= QUIET_LO) && (cycle < QUIET_HI);

  always @(posedge clk) begin
    pair_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) load_pair('{sym: in_symbol, freq: in_frequency, last: in_last});
      if (pair_q.size() > 0 && (quiet || $urandom_range(99) >= 18)) begin
        p = pair_q.pop_front();
        in_valid <= 1'b1;
        in_symbol <= p.sym;
        in_frequency <= p.freq;
        in_last <= p.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off so the block backs up
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (cycle >= HOLD_START && hold_cnt < HOLD_LEN) hold_cnt <= hold_cnt + 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (cycle >= HOLD_START && hold_cnt < HOLD_LEN) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 18);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each result transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    code_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{sym: out_symbol, len: out_code_length, code: out_code_bits,
              fin: out_final_res, err: out_error};
      if (code_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sym %0d len %0d code %h final %b err %b",
                   got.sym, got.len, got.code, got.fin, got.err);
      end else begin
        want = code_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp sym %0d len %0d code %h final %b err %b / act sym %0d len %0d code %h final %b err %b",
                     want.sym, want.len, want.code, want.fin, want.err,
                     got.sym, got.len, got.code, got.fin, got.err);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT_CYC) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    clear_set();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (fill_done && pair_q.size() == 0 && !in_valid && code_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && code_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
